// ===== design/rcrc_pkg.sv =====
// Shared types, register indexes and polynomials for the reflected CRC engine.
package rcrc_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CRC_W-1:0] POLY_FCS16   = 32'h0000_8408;
    localparam logic [CRC_W-1:0] POLY_MODBUS  = 32'h0000_A001;
    localparam logic [CRC_W-1:0] POLY_CRC32   = 32'hEDB8_8320;
    localparam logic [15:0]      MODBUS_START = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_RESET    = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] INIT_RESET   = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = 2'd1;

    typedef enum logic [1:0] {
        MODE_FCS16  = 2'd0,
        MODE_MODBUS = 2'd1,
        MODE_CRC32  = 2'd2
    } crc_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } crc_in_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             crc_final;
    } crc_out_t;

    typedef struct packed {
        crc_mode_t        mode;
        logic [CRC_W-1:0] init_value;
    } crc_cfg_t;

endpackage

// ===== design/rcrc_cfg_regs.sv =====
// Configuration register file: CRC mode and initial value.
module rcrc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcrc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rcrc_pkg::crc_cfg_t                  cfg
);

    rcrc_pkg::crc_mode_t             mode_reg;
    rcrc_pkg::crc_mode_t             mode_next;
    logic [rcrc_pkg::CRC_W-1:0]      init_reg;
    logic [rcrc_pkg::CRC_W-1:0]      init_next;

    // Writes are always taken; indexes past the register list fall through.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        init_next = init_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rcrc_pkg::REG_CRC_MODE:
                begin
                    mode_next = rcrc_pkg::crc_mode_t'(cfg_data[1:0]);
                end
                rcrc_pkg::REG_INIT_VALUE:
                begin
                    init_next = cfg_data;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rcrc_pkg::MODE_FCS16;
            init_reg <= rcrc_pkg::INIT_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            init_reg <= init_next;
        end
    end

    assign cfg.mode       = mode_reg;
    assign cfg.init_value = init_reg;

endmodule

// ===== design/rcrc_fold.sv =====
// Combinational byte fold: picks the start value and polynomial, then
// shifts eight bits through the reflected CRC.
module rcrc_fold (
    input  rcrc_pkg::crc_cfg_t               cfg,
    input  logic [rcrc_pkg::CRC_W-1:0]       running_crc,
    input  logic [rcrc_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             first_byte,
    output logic [rcrc_pkg::CRC_W-1:0]       crc_result
);

    logic [rcrc_pkg::CRC_W-1:0] start;
    logic [rcrc_pkg::CRC_W-1:0] poly;
    logic [rcrc_pkg::CRC_W-1:0] shift_crc;

    // Sixteen-bit modes keep the upper half zero; with a 16-bit polynomial
    // the right shifts never bring a one into it.
    always_comb
    begin
        case (cfg.mode)
            rcrc_pkg::MODE_FCS16:
            begin
                poly  = rcrc_pkg::POLY_FCS16;
                start = first_byte ? {16'h0000, cfg.init_value[15:0]}
                                   : {16'h0000, running_crc[15:0]};
            end
            rcrc_pkg::MODE_MODBUS:
            begin
                poly  = rcrc_pkg::POLY_MODBUS;
                start = first_byte ? {16'h0000, rcrc_pkg::MODBUS_START}
                                   : {16'h0000, running_crc[15:0]};
            end
            default:
            begin
                // CRC-32 and the unused code 3 share the 32-bit path.
                poly  = rcrc_pkg::POLY_CRC32;
                start = first_byte ? cfg.init_value : running_crc;
            end
        endcase
    end

    always_comb
    begin
        shift_crc = start ^ {{(rcrc_pkg::CRC_W-rcrc_pkg::BYTE_W){1'b0}}, data_byte};
        for (int b = 0; b < rcrc_pkg::BYTE_W; b++)
        begin
            shift_crc = shift_crc[0] ? ((shift_crc >> 1) ^ poly) : (shift_crc >> 1);
        end
        crc_result = shift_crc;
    end

endmodule

// ===== design/reflected_crc16_crc32_engine.sv =====
// Top level of the reflected byte-serial CRC engine (FCS-16, MODBUS, CRC-32).
//
//  Channel   Signals                                   Direction  Moves
//  input     in_valid, in_stall, in_data               in         one byte request
//  output    out_valid, out_stall, out_data            out        running CRC, final flag
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         register write
//
// A request is taken into the input register, folded through eight unrolled
// shift steps and stored in the result register once that register is free.
// One request per cycle is sustained while the output is not stalled; the
// running CRC register closes the loop between consecutive bytes through the
// fold logic.
// Reset (rst_n low, asynchronous) empties both stages, sets mode FCS-16,
// the initial value and the running CRC to all ones.
// A stalled result holds the result register; a full input register then holds
// too, and in_stall rises only while both stages are full.
module reflected_crc16_crc32_engine (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  rcrc_pkg::crc_in_t                in_data,

    output logic                             out_valid,
    input  logic                             out_stall,
    output rcrc_pkg::crc_out_t               out_data,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rcrc_pkg::crc_cfg_t             cfg;

    // Input stage.
    logic                           req_valid_reg;
    logic                           req_valid_next;
    rcrc_pkg::crc_in_t              req_reg;
    rcrc_pkg::crc_in_t              req_next;

    // Result stage and the running CRC that carries between bytes.
    logic                           res_valid_reg;
    logic                           res_valid_next;
    rcrc_pkg::crc_out_t             res_reg;
    rcrc_pkg::crc_out_t             res_next;
    logic [rcrc_pkg::CRC_W-1:0]     running_crc_reg;
    logic [rcrc_pkg::CRC_W-1:0]     running_crc_next;

    logic [rcrc_pkg::CRC_W-1:0]     crc_result;
    logic                           res_free;
    logic                           advance;
    logic                           req_take;

    rcrc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcrc_fold u_fold (
        .cfg         (cfg),
        .running_crc (running_crc_reg),
        .data_byte   (req_reg.data_byte),
        .first_byte  (req_reg.first_byte),
        .crc_result  (crc_result)
    );

    // The result register can load whenever it is empty or being drained.
    assign res_free = !res_valid_reg || !out_stall;
    // The held request moves on into the result register.
    assign advance  = req_valid_reg && res_free;
    // The input register is free when empty or when its request moves on.
    assign in_stall = req_valid_reg && !res_free;
    assign req_take = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next   = req_valid_reg;
        req_next         = req_reg;
        res_valid_next   = res_valid_reg;
        res_next         = res_reg;
        running_crc_next = running_crc_reg;

        if (res_free)
        begin
            res_valid_next = advance;
        end
        if (advance)
        begin
            res_next.crc_value = crc_result;
            res_next.crc_final = req_reg.last_byte;
            // The next byte sees this result in the following cycle.
            running_crc_next   = crc_result;
        end

        if (!req_valid_reg || advance)
        begin
            req_valid_next = in_valid;
        end
        if (req_take)
        begin
            req_next = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            running_crc_reg <= rcrc_pkg::CRC_RESET;
        end
        else
        begin
            req_valid_reg   <= req_valid_next;
            res_valid_reg   <= res_valid_next;
            running_crc_reg <= running_crc_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule

// ===== design/rcrc_checker.sv =====
// Port-level checker for the CRC engine and its bind to the top level.
module rcrc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  rcrc_pkg::crc_out_t  out_data,
    input  logic                cfg_ready
);

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Back-pressure on input only arises from a stalled, full result stage.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // An accepted request moves on from the input register and shows up at the
    // output unless the result stage is held.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !(out_valid && out_stall) |=> out_valid)
        else $error("accepted request did not produce a result");

    // Register writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind reflected_crc16_crc32_engine rcrc_checker u_rcrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
